// ----- hw/rtl/dns_name_label_encoder_top_macros.svh -----
// Assertion macros for the DNS name label encoder.
// Used by dns_name_label_encoder_top; expects clk and arst_n in scope.
`ifndef DNS_NAME_LABEL_ENCODER_TOP_MACROS_SVH
`define DNS_NAME_LABEL_ENCODER_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define DNLE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define DNLE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/dnle_pkg.sv -----
// Shared constants and types for the DNS name label encoder.
// No dependencies; imported by every module of the block.
`default_nettype none
package dnle_pkg;

	localparam int MAX_LABEL = 62;
	localparam int CNT_W = 6;
	localparam int ADDR_W = CNT_W + 1;
	localparam int MEM_DEPTH = 2 ** ADDR_W;
	localparam int CMD_DEPTH = 2;
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = 2;
	localparam int OQ_CNT_W = 3;

	localparam logic [7:0] DOT_CHAR = 8'h2E;
	localparam logic [7:0] END_CHAR = 8'h00;

	typedef struct packed {
		logic             bank;
		logic [CNT_W-1:0] count;
		logic             cut;
		logic             is_end;
	} label_cmd_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [7:0]        data;
	} mem_wr_t;

	typedef struct packed {
		logic [CNT_W-1:0] count;
		logic             bank;
		logic             delim;
		logic             accept;
	} front_status_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       trunc;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_LEN  = 4'b0010,
		ST_DATA = 4'b0100,
		ST_END  = 4'b1000
	} back_state_t;

endpackage
`default_nettype wire

// ----- hw/rtl/dnle_front.sv -----
// Front end: accepts name bytes, stores label bytes, issues drain commands.
// Depends on dnle_pkg.
`default_nettype none
module dnle_front (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   push,
	input  wire logic [7:0]             name_char,
	input  wire logic                   q_full,
	output logic                        full,
	output dnle_pkg::mem_wr_t           mem_wr,
	output logic                        cmd_push,
	output dnle_pkg::label_cmd_t        cmd,
	output dnle_pkg::front_status_t     status
);
	import dnle_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic             cut_q;
	logic             bank_q;
	logic             accept;
	logic             delim;
	logic             room;

	assign full   = q_full;
	assign accept = push && !q_full;
	assign delim  = (name_char == DOT_CHAR) || (name_char == END_CHAR);
	assign room   = count_q < CNT_W'(MAX_LABEL);

	assign mem_wr.en   = accept && !delim && room;
	assign mem_wr.addr = {bank_q, count_q};
	assign mem_wr.data = name_char;

	assign cmd_push    = accept && delim;
	assign cmd.bank    = bank_q;
	assign cmd.count   = count_q;
	assign cmd.cut     = cut_q;
	assign cmd.is_end  = (name_char == END_CHAR);

	assign status.count  = count_q;
	assign status.bank   = bank_q;
	assign status.delim  = delim;
	assign status.accept = accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			cut_q   <= 1'b0;
			bank_q  <= 1'b0;
		end else if (accept) begin
			if (delim) begin
				// close the label and move on to the other bank
				count_q <= '0;
				cut_q   <= 1'b0;
				bank_q  <= !bank_q;
			end else if (room) begin
				count_q <= count_q + 1'b1;
			end else begin
				cut_q <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/dnle_cmdq.sv -----
// Two-entry queue of label drain commands between front and back.
// Depends on dnle_pkg.
`default_nettype none
module dnle_cmdq (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire dnle_pkg::label_cmd_t wr_cmd,
	input  wire logic                 rd_en,
	input  wire logic                 back_busy,
	output dnle_pkg::label_cmd_t      rd_cmd,
	output logic                      q_empty,
	output logic                      q_full,
	output logic [1:0]                q_count
);
	import dnle_pkg::*;

	label_cmd_t entry_q [0:CMD_DEPTH-1];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] count_q;
	logic       do_wr;
	logic       do_rd;

	assign q_empty = (count_q == 2'd0);
	// a bank in use by the back end is as good as queued
	assign q_full  = ({1'b0, count_q} + {2'b0, back_busy}) >= 3'(CMD_DEPTH);
	assign q_count = count_q;
	assign rd_cmd  = entry_q[rptr_q];
	assign do_wr   = wr_en;
	assign do_rd   = rd_en && !q_empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_wr) begin
				wptr_q <= !wptr_q;
			end
			if (do_rd) begin
				rptr_q <= !rptr_q;
			end
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/dnle_back.sv -----
// Back end: label memory, drain sequencer and result queue.
// Depends on dnle_pkg.
`default_nettype none
module dnle_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire dnle_pkg::mem_wr_t    mem_wr,
	input  wire dnle_pkg::label_cmd_t cmd,
	input  wire logic                 cmd_empty,
	output logic                      cmd_pop,
	output logic                      busy,
	input  wire logic                 pop,
	output logic                      empty,
	output dnle_pkg::result_t         head
);
	import dnle_pkg::*;

	logic [7:0]        mem_q [0:MEM_DEPTH-1];
	back_state_t       state_q;
	back_state_t       state_d;
	label_cmd_t        cur_q;
	logic [CNT_W-1:0]  idx_q;
	logic [ADDR_W-1:0] rd_addr;

	logic       valid_s2;
	logic       from_mem_s2;
	logic [7:0] byte_s2;
	logic       last_s2;
	logic       trunc_s2;
	logic [7:0] rd_s2;

	result_t             oq_q [0:OQ_DEPTH-1];
	logic [OQ_PTR_W-1:0] owptr_q;
	logic [OQ_PTR_W-1:0] orptr_q;
	logic [OQ_CNT_W-1:0] ocount_q;
	logic                can_issue;
	logic                issue;
	logic                oq_pop;
	result_t             oq_in;
	logic                data_done;

	assign rd_addr   = {cur_q.bank, idx_q};
	// count results already in flight so the queue never overflows
	assign can_issue = ({1'b0, ocount_q} + {{OQ_CNT_W{1'b0}}, valid_s2})
		< (OQ_CNT_W + 1)'(OQ_DEPTH);
	assign issue     = (state_q != ST_IDLE) && can_issue;
	assign cmd_pop   = (state_q == ST_IDLE) && !cmd_empty;
	assign busy      = (state_q != ST_IDLE);
	assign data_done = (CNT_W'(idx_q + 1'b1) == cur_q.count);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (!cmd_empty) begin
					state_d = ST_LEN;
				end
			end
			ST_LEN: begin
				if (can_issue) begin
					if (cur_q.count != '0) begin
						state_d = ST_DATA;
					end else if (cur_q.is_end) begin
						state_d = ST_END;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_DATA: begin
				if (can_issue && data_done) begin
					state_d = cur_q.is_end ? ST_END : ST_IDLE;
				end
			end
			ST_END: begin
				if (can_issue) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_wr.en) begin
			mem_q[mem_wr.addr] <= mem_wr.data;
		end
		rd_s2 <= mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			cur_q <= cmd;
		end
		if (issue) begin
			from_mem_s2 <= (state_q == ST_DATA);
			byte_s2     <= (state_q == ST_LEN) ? {2'b00, cur_q.count} : 8'h00;
			last_s2     <= (state_q == ST_END);
			trunc_s2    <= (state_q == ST_END) ? 1'b0 : cur_q.cut;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			idx_q    <= '0;
			valid_s2 <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s2 <= issue;
			if (cmd_pop) begin
				idx_q <= '0;
			end else if (issue && (state_q == ST_DATA)) begin
				idx_q <= idx_q + 1'b1;
			end
		end
	end

	// result queue
	assign oq_in.data  = from_mem_s2 ? rd_s2 : byte_s2;
	assign oq_in.last  = last_s2;
	assign oq_in.trunc = trunc_s2;
	assign empty       = (ocount_q == '0);
	assign oq_pop      = pop && !empty;
	assign head        = oq_q[orptr_q];

	always_ff @(posedge clk) begin
		if (valid_s2) begin
			oq_q[owptr_q] <= oq_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owptr_q  <= '0;
			orptr_q  <= '0;
			ocount_q <= '0;
		end else begin
			if (valid_s2) begin
				owptr_q <= owptr_q + 1'b1;
			end
			if (oq_pop) begin
				orptr_q <= orptr_q + 1'b1;
			end
			case ({valid_s2, oq_pop})
				2'b10:   ocount_q <= ocount_q + 1'b1;
				2'b01:   ocount_q <= ocount_q - 1'b1;
				default: ocount_q <= ocount_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/dns_name_label_encoder_top.sv -----
// Top level of the DNS name label encoder: front, command queue, back.
// Depends on dnle_pkg, dnle_front, dnle_cmdq, dnle_back and the macros header.
`default_nettype none
// Takes a dotted host name one byte per item (a zero byte ends the name) and
// emits its DNS wire form: per label a length byte then the label bytes, and
// after the last label a zero byte with out_last set. Labels longer than 62
// bytes are cut to 62 and their results carry out_truncated. Ordinary bytes
// are taken one per cycle while full is low. A dot or the terminator hands
// the label to the drain sequencer, which loads the command and then emits
// one result per cycle while the result queue has room. Two label banks let
// the next label fill while one drains; the input stalls (full) only when
// both banks wait on the drain sequencer, and a four-entry result queue
// keeps the drain going while pop is low.
module dns_name_label_encoder_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] name_char,
	output logic            empty,
	input  wire logic       pop,
	output logic [7:0]      out_byte,
	output logic            out_last,
	output logic            out_truncated
);
	import dnle_pkg::*;

	`include "dns_name_label_encoder_top_macros.svh"

	mem_wr_t       mem_wr;
	logic          cmd_push;
	label_cmd_t    cmd_in;
	label_cmd_t    cmd_out;
	logic          cmd_empty;
	logic          cmd_full;
	logic [1:0]    cmd_count;
	logic          cmd_pop;
	logic          back_busy;
	front_status_t front_st;
	result_t       head;

	dnle_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.name_char (name_char),
		.q_full    (cmd_full),
		.full      (full),
		.mem_wr    (mem_wr),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in),
		.status    (front_st)
	);

	dnle_cmdq u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (cmd_push),
		.wr_cmd    (cmd_in),
		.rd_en     (cmd_pop),
		.back_busy (back_busy),
		.rd_cmd    (cmd_out),
		.q_empty   (cmd_empty),
		.q_full    (cmd_full),
		.q_count   (cmd_count)
	);

	dnle_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mem_wr    (mem_wr),
		.cmd       (cmd_out),
		.cmd_empty (cmd_empty),
		.cmd_pop   (cmd_pop),
		.busy      (back_busy),
		.pop       (pop),
		.empty     (empty),
		.head      (head)
	);

	assign out_byte      = head.data;
	assign out_last      = head.last;
	assign out_truncated = head.trunc;

	`DNLE_ASSERT_NOW(a_bank_owners, 1'b1, ({1'b0, cmd_count} + {2'b0, back_busy}) <= 3'd2, "more labels pending than banks")
	`DNLE_ASSERT_NEXT(a_bank_flip, front_st.accept && front_st.delim, (front_st.bank != $past(front_st.bank)) && (front_st.count == '0), "delimiter did not close the label")
	`DNLE_ASSERT_NOW(a_last_is_zero, !empty && out_last, (out_byte == 8'h00) && !out_truncated, "final result is not a plain zero byte")

endmodule
`default_nettype wire
